// ----- src/aabbct_pkg.sv -----
// Shared types and constants for the box pair contact tracker.
`timescale 1ns / 1ps

package aabbct_pkg;

  // Width of a collider number field on the input stream.
  localparam int ID_W = 6;

  // Width of the contact event code.
  localparam int EVENT_W = 2;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_t;

endpackage

// ----- src/aabbct_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module aabbct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same address in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/aabb_pair_contact_tracker_top.sv -----
// Top level of the box pair contact tracker: overlap test and touching-bit table.
//
//   Channel   Direction  Beat contents
//   s_axis    in         ids, both box centres and sizes (see s_tdata)
//   m_axis    out        contact event and current overlap flag
//
// One beat in and one beat out per pair, one pair per cycle sustained.
// Each pair passes the input register with the touching-bit read, then the
// result register; the bit read of back-to-back pairs is forwarded from
// the previous write. After reset a clearing pass writes every table entry,
// 2**(2*IDX_W) entries (4096 at the default), with s_tready low. A stall on
// m_tready holds both stages; outside the clearing pass s_tready drops only when both are full.
`timescale 1ns / 1ps

module aabb_pair_contact_tracker_top #(
  parameter int COLLIDER_COUNT = 64,
  parameter int COORD_BITS     = 20
) (
  input  logic clk,
  input  logic rst,

  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // first_id, second_id, first_x, first_y, second_x, second_y, first_width,
  // first_height, second_width, second_height, zero fill to whole bytes
  input  logic [((2*aabbct_pkg::ID_W+8*COORD_BITS+7)/8)*8-1:0] s_tdata,

  output logic       m_tvalid,
  input  logic       m_tready,
  // contact_event, overlapping, zero fill
  output logic [7:0] m_tdata
);

  import aabbct_pkg::*;

  localparam int EFF_COUNT = (COLLIDER_COUNT < (1 << ID_W)) ? COLLIDER_COUNT : (1 << ID_W);
  localparam int IDX_W     = $clog2(EFF_COUNT);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int CB        = COORD_BITS;
  localparam int CO        = 2 * ID_W;

  typedef logic signed [CB-1:0] coord_t;

  // Strict overlap on one axis: 2*|c1-c2| < |s1+s2|.
  function automatic logic axis_overlap(coord_t c1, coord_t c2, coord_t s1, coord_t s2);
    logic signed [CB:0] diff;
    logic signed [CB:0] sum;
    logic [CB:0]        gap;
    logic [CB:0]        span;
    diff = {c1[CB-1], c1} - {c2[CB-1], c2};
    sum  = {s1[CB-1], s1} + {s2[CB-1], s2};
    gap  = diff[CB] ? (~diff + 1'b1) : diff;
    span = sum[CB] ? (~sum + 1'b1) : sum;
    return {gap, 1'b0} < {1'b0, span};
  endfunction

  // Input fields.
  logic [ID_W-1:0] in_first_id;
  logic [ID_W-1:0] in_second_id;
  logic            in_ids_ok;
  logic [ADDR_W-1:0] in_addr;

  assign in_first_id  = s_tdata[ID_W-1:0];
  assign in_second_id = s_tdata[2*ID_W-1:ID_W];
  assign in_ids_ok    = (32'(in_first_id) < 32'(COLLIDER_COUNT)) &&
                        (32'(in_second_id) < 32'(COLLIDER_COUNT));
  assign in_addr      = {in_first_id[IDX_W-1:0], in_second_id[IDX_W-1:0]};

  // Stage 1 registers.
  logic              s1_valid;
  logic              s1_ids_ok;
  logic [ADDR_W-1:0] s1_addr;
  coord_t            s1_first_x, s1_first_y, s1_second_x, s1_second_y;
  coord_t            s1_first_w, s1_first_h, s1_second_w, s1_second_h;

  // Clearing pass.
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // Forwarding of the most recent table write.
  logic              last_wr_valid;
  logic [ADDR_W-1:0] last_wr_addr;
  logic              last_wr_data;

  logic              s1_adv;
  logic              accept;
  logic              hit;
  logic              touching;
  logic              ram_rd_data;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic              ram_wr_data;
  logic              tbl_wr;
  contact_event_t    event_next;
  contact_event_t    out_event;
  logic              out_overlap;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  assign hit = axis_overlap(s1_first_x, s1_second_x, s1_first_w, s1_second_w) &&
               axis_overlap(s1_first_y, s1_second_y, s1_first_h, s1_second_h);

  assign touching = (last_wr_valid && (last_wr_addr == s1_addr)) ? last_wr_data
                                                                 : ram_rd_data;

  always_comb begin
    event_next = EV_NONE;
    if (s1_ids_ok) begin
      if (hit) begin
        event_next = touching ? EV_STAY : EV_ENTER;
      end else if (touching) begin
        event_next = EV_EXIT;
      end
    end
  end

  assign tbl_wr      = s1_adv && s1_ids_ok;
  assign ram_wr_en   = clearing || tbl_wr;
  assign ram_wr_addr = clearing ? clr_addr : s1_addr;
  assign ram_wr_data = clearing ? 1'b0 : hit;

  aabbct_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_touch_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      clearing      <= 1'b1;
      clr_addr      <= '0;
      last_wr_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (ram_wr_en) begin
        last_wr_valid <= 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ram_wr_en) begin
      last_wr_addr <= ram_wr_addr;
      last_wr_data <= ram_wr_data;
    end
    if (accept) begin
      s1_ids_ok   <= in_ids_ok;
      s1_addr     <= in_addr;
      s1_first_x  <= s_tdata[CO+1*CB-1 -: CB];
      s1_first_y  <= s_tdata[CO+2*CB-1 -: CB];
      s1_second_x <= s_tdata[CO+3*CB-1 -: CB];
      s1_second_y <= s_tdata[CO+4*CB-1 -: CB];
      s1_first_w  <= s_tdata[CO+5*CB-1 -: CB];
      s1_first_h  <= s_tdata[CO+6*CB-1 -: CB];
      s1_second_w <= s_tdata[CO+7*CB-1 -: CB];
      s1_second_h <= s_tdata[CO+8*CB-1 -: CB];
    end
    if (s1_adv) begin
      out_event   <= event_next;
      out_overlap <= hit;
    end
  end

  assign m_tdata = {5'b0, out_overlap, out_event};

endmodule

// ----- tb/tb_aabb_pair_contact_tracker_top.sv -----
// Self-checking testbench for the box pair contact tracker top level.
`timescale 1ns / 1ps

module tb_aabb_pair_contact_tracker_top;
  import aabbct_pkg::*;

  localparam int COLLIDER_COUNT = 64;
  localparam int COORD_BITS     = 20;
  localparam int S_W            = ((2*ID_W+8*COORD_BITS+7)/8)*8;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int CALM_ITEMS     = 300;
  localparam int MAX_REPORTS    = 10;
  // The clearing pass after reset, which writes 4096 table entries, counts as quiet.
  localparam int QUIET_LIMIT    = 20000;

  typedef struct packed {
    logic [ID_W-1:0]              first_id;
    logic [ID_W-1:0]              second_id;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] first_width;
    logic signed [COORD_BITS-1:0] first_height;
    logic signed [COORD_BITS-1:0] second_width;
    logic signed [COORD_BITS-1:0] second_height;
  } box_pair_t;

  typedef struct packed {
    contact_event_t ev;
    logic           overlapping;
  } contact_result_t;

  typedef struct {
    box_pair_t       boxes;
    bit              typed;
    contact_result_t result;
  } directed_row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [S_W-1:0] s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [7:0]     m_tdata;

  bit              touching_bits [COLLIDER_COUNT*COLLIDER_COUNT];
  contact_result_t expected_contacts [$];
  directed_row_t   directed_rows [$];
  bit              calm = 1'b0;
  int              mismatches = 0;
  int              quiet_cycles = 0;

  aabb_pair_contact_tracker_top #(
    .COLLIDER_COUNT(COLLIDER_COUNT),
    .COORD_BITS    (COORD_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit axis_hit(longint c1, longint c2, longint s1, longint s2);
    longint gap;
    longint span;
    gap = c1 - c2;
    span = s1 + s2;
    if (gap < 0) gap = -gap;
    if (span < 0) span = -span;
    return 2 * gap < span;
  endfunction

  // Computes the contact event for one pair and updates the touching table.
  function automatic contact_result_t track_contact(box_pair_t p);
    contact_result_t res;
    int              idx;
    bit              was;
    res.overlapping = axis_hit(p.first_x, p.second_x, p.first_width, p.second_width) &&
                      axis_hit(p.first_y, p.second_y, p.first_height, p.second_height);
    res.ev = EV_NONE;
    if (p.first_id < COLLIDER_COUNT && p.second_id < COLLIDER_COUNT) begin
      idx = p.first_id * COLLIDER_COUNT + p.second_id;
      was = touching_bits[idx];
      if (res.overlapping) begin
        res.ev = was ? EV_STAY : EV_ENTER;
        touching_bits[idx] = 1'b1;
      end else if (was) begin
        res.ev = EV_EXIT;
        touching_bits[idx] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic directed_row_t row(int a, int b, int x1, int y1, int x2, int y2,
                                        int w1, int h1, int w2, int h2, int typed,
                                        contact_event_t ev, int ov);
    directed_row_t r;
    r.boxes = '{ID_W'(a), ID_W'(b), COORD_BITS'(x1), COORD_BITS'(y1), COORD_BITS'(x2),
                COORD_BITS'(y2), COORD_BITS'(w1), COORD_BITS'(h1), COORD_BITS'(w2),
                COORD_BITS'(h2)};
    r.typed = (typed != 0);
    r.result.ev = ev;
    r.result.overlapping = (ov != 0);
    return r;
  endfunction

  // Drives one pair beat, waits for it to be taken and queues what it must produce.
  task automatic send_pair(input box_pair_t p, input bit typed, input contact_result_t typed_res);
    contact_result_t res;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {4'b0, p.second_height, p.second_width, p.first_height, p.first_width,
               p.second_y, p.second_x, p.first_y, p.first_x, p.second_id, p.first_id};
    do @(posedge clk); while (!s_tready);
    res = track_contact(p);
    expected_contacts.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Result side: random stall bursts, none once the run has turned calm.
  initial begin
    forever begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(50, 150) : $urandom_range(1, 20))
        @(negedge clk) m_tready = 1'b1;
      if (!calm) begin
        repeat ($urandom_range(1, 9)) @(negedge clk) m_tready = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    contact_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: event %0d overlapping %0b",
                   m_tdata[1:0], m_tdata[2]);
      end else begin
        want = expected_contacts.pop_front();
        if (m_tdata[1:0] !== want.ev || m_tdata[2] !== want.overlapping) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"result mismatch: expected event %0d overlapping %0b, ",
                      "got event %0d overlapping %0b"},
                     want.ev, want.overlapping, m_tdata[1:0], m_tdata[2]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_aabb_pair_contact_tracker_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    box_pair_t       p;
    contact_result_t none_res;
    int              mode;
    int              cx;
    int              cy;
    int              dx;
    int              w1;
    none_res = '{EV_NONE, 1'b0};

    // Enter, stay, exit and none on one pair, with the reversed pair entering on its own in between.
    directed_rows.push_back(row(3, 5, 0, 0, 16, 16, 64, 64, 64, 64, 1, EV_ENTER, 1));
    directed_rows.push_back(row(3, 5, 0, 0, 16, 16, 64, 64, 64, 64, 1, EV_STAY, 1));
    directed_rows.push_back(row(5, 3, 0, 0, 16, 16, 64, 64, 64, 64, 1, EV_ENTER, 1));
    directed_rows.push_back(row(3, 5, 0, 0, 1000, 16, 64, 64, 64, 64, 1, EV_EXIT, 0));
    directed_rows.push_back(row(3, 5, 0, 0, 1000, 16, 64, 64, 64, 64, 1, EV_NONE, 0));
    // A box against its own number, then touching edges, which do not count.
    directed_rows.push_back(row(7, 7, 0, 0, 0, 0, 64, 64, 64, 64, 1, EV_ENTER, 1));
    directed_rows.push_back(row(7, 7, 0, 0, 64, 0, 64, 64, 64, 64, 1, EV_EXIT, 0));
    directed_rows.push_back(row(9, 10, 0, 0, 0, 64, 64, 64, 64, 64, 1, EV_NONE, 0));
    directed_rows.push_back(row(9, 10, 0, 0, 63, 63, 64, 64, 64, 64, 1, EV_ENTER, 1));
    // Negative sizes of one sign act as magnitudes; mixed signs can cancel.
    directed_rows.push_back(row(11, 12, 0, 0, 10, 10, -64, -64, -64, -64, 1, EV_ENTER, 1));
    directed_rows.push_back(row(11, 13, 0, 0, 0, 0, 64, 64, -64, -64, 1, EV_NONE, 0));
    // Coordinate and size extremes.
    directed_rows.push_back(row(0, 0, 524287, 524287, 524287, 524287,
                                524287, 524287, 524287, 524287, 1, EV_ENTER, 1));
    directed_rows.push_back(row(63, 63, -524288, -524288, -524288, -524288,
                                -524288, -524288, -524288, -524288, 1, EV_ENTER, 1));
    directed_rows.push_back(row(63, 0, 524287, 524287, -524288, -524288,
                                524287, 524287, 524287, 524287, 1, EV_NONE, 0));
    directed_rows.push_back(row(0, 63, -524288, -524288, 524287, 524287,
                                -524288, -524288, -524288, -524288, 1, EV_NONE, 0));
    directed_rows.push_back(row(63, 63, 5, 5, 5, 5, 0, 0, 0, 0, 1, EV_EXIT, 0));
    // Mixed cases left to the predictor.
    directed_rows.push_back(row(1, 2, -100, 40, 200, -30, 500, 90, 300, 60, 0, EV_NONE, 0));
    directed_rows.push_back(row(2, 1, -100, 40, 200, -30, 500, 90, 300, 60, 0, EV_NONE, 0));
    directed_rows.push_back(row(1, 2, -100, 40, 201, -30, 500, 90, 100, 60, 0, EV_NONE, 0));
    directed_rows.push_back(row(12, 11, 300, -300, 290, -310, -40, 30, 10, -30, 0, EV_NONE, 0));
    directed_rows.push_back(row(9, 10, 524287, 0, -524288, 0, 1, 1, 1, 1, 0, EV_NONE, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_pair(directed_rows[i].boxes, directed_rows[i].typed, directed_rows[i].result);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      mode = $urandom_range(0, 99);
      cx = int'($urandom_range(0, 1000000)) - 500000;
      cy = int'($urandom_range(0, 1000000)) - 500000;
      p.first_id  = ID_W'($urandom_range(0, 5));
      p.second_id = ID_W'($urandom_range(0, 5));
      p.first_x   = COORD_BITS'(cx);
      p.first_y   = COORD_BITS'(cy);
      if (mode < 70) begin
        // Nearby boxes from a small set of ids, so pairs go through all events.
        p.second_x      = COORD_BITS'(cx + int'($urandom_range(0, 400)) - 200);
        p.second_y      = COORD_BITS'(cy + int'($urandom_range(0, 400)) - 200);
        p.first_width   = COORD_BITS'($urandom_range(0, 300));
        p.first_height  = COORD_BITS'($urandom_range(0, 300));
        p.second_width  = COORD_BITS'($urandom_range(0, 300));
        p.second_height = COORD_BITS'($urandom_range(0, 300));
        if ($urandom_range(0, 9) == 0) begin
          p.first_width   = -p.first_width;
          p.second_width  = -p.second_width;
          p.first_height  = -p.first_height;
          p.second_height = -p.second_height;
        end
      end else if (mode < 88) begin
        // Size sum within one of twice the x distance.
        dx = $urandom_range(0, 150);
        w1 = $urandom_range(0, 2*dx + 1);
        p.second_x      = COORD_BITS'(cx + dx);
        p.second_y      = COORD_BITS'(cy + int'($urandom_range(0, 20)) - 10);
        p.first_width   = COORD_BITS'(w1);
        p.second_width  = COORD_BITS'(2*dx - w1 + int'($urandom_range(0, 2)) - 1);
        p.first_height  = COORD_BITS'(100);
        p.second_height = COORD_BITS'(100);
      end else begin
        p.first_id      = ID_W'($urandom);
        p.second_id     = ID_W'($urandom);
        p.first_x       = COORD_BITS'($urandom);
        p.first_y       = COORD_BITS'($urandom);
        p.second_x      = COORD_BITS'($urandom);
        p.second_y      = COORD_BITS'($urandom);
        p.first_width   = COORD_BITS'($urandom);
        p.first_height  = COORD_BITS'($urandom);
        p.second_width  = COORD_BITS'($urandom);
        p.second_height = COORD_BITS'($urandom);
      end
      send_pair(p, 1'b0, none_res);
    end
    s_tvalid = 1'b0;

    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_aabb_pair_contact_tracker_top: PASS");
    end else begin
      $display("tb_aabb_pair_contact_tracker_top: FAIL");
    end
    $finish;
  end

endmodule
